/* rtl/core/qte_pkg.sv */
// Shared constants, types and tables for the quaternion to Euler angle pipeline.
`timescale 1ns / 1ps

package qte_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int CRD_LAT       = CORDIC_STAGES + 1;

    localparam int PROD_W    = 32;
    localparam int SUM_W     = 36;
    localparam int CRD_W     = 37;
    localparam int ANG_W     = 20;
    localparam int SINP_W    = 29;
    localparam int SQ_IN_W   = 56;
    localparam int SQ_W      = 58;
    localparam int SQ_ROOT_W = 29;
    localparam int SQ_STEPS  = SQ_IN_W / 2 + 1;
    localparam int SQ_LAT    = SQ_STEPS + 1;

    localparam logic signed [ANG_W-1:0] ANG_PI = ANG_W'(205887);
    localparam int OUT_PI      = 25736;
    localparam int OUT_HALF_PI = 12868;

    localparam logic signed [SUM_W-1:0] ONE_Q28 = SUM_W'(1) <<< 28;

    typedef enum logic [1:0] {
        CONV_STANDARD = 2'd0,
        CONV_GIMBAL   = 2'd1,
        CONV_TARGET   = 2'd2
    } t_conv;

    typedef struct packed {
        logic signed [SUM_W-1:0]  sinr;
        logic signed [SUM_W-1:0]  cosr;
        logic signed [SUM_W-1:0]  siny;
        logic signed [SUM_W-1:0]  cosy;
        logic signed [SINP_W-1:0] sinp;
        logic                     clamped;
        logic                     positive;
    } t_side;

    typedef struct packed {
        logic clamped;
        logic positive;
    } t_pflag;

    function automatic logic signed [ANG_W-1:0] atan_entry(input int idx);
        logic signed [ANG_W-1:0] val;
        case (idx)
            0:       val = ANG_W'(51472);
            1:       val = ANG_W'(30385);
            2:       val = ANG_W'(16055);
            3:       val = ANG_W'(8150);
            4:       val = ANG_W'(4091);
            5:       val = ANG_W'(2047);
            6:       val = ANG_W'(1024);
            7:       val = ANG_W'(512);
            8:       val = ANG_W'(256);
            9:       val = ANG_W'(128);
            10:      val = ANG_W'(64);
            11:      val = ANG_W'(32);
            12:      val = ANG_W'(16);
            13:      val = ANG_W'(8);
            14:      val = ANG_W'(4);
            15:      val = ANG_W'(2);
            16:      val = ANG_W'(1);
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

/* rtl/core/qte_isqrt.sv */
// Pipelined digit-by-digit integer square root of one minus the squared pitch sine.
`timescale 1ns / 1ps

module qte_isqrt
    import qte_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [SQ_IN_W-1:0]   i_sq,
    output logic                 o_valid,
    output logic [SQ_ROOT_W-1:0] o_root
);

    logic            r_v    [0:SQ_STEPS];
    logic [SQ_W-1:0] r_rem  [0:SQ_STEPS];
    logic [SQ_W-1:0] r_root [0:SQ_STEPS];
    logic [SQ_W-1:0] n_rem  [0:SQ_STEPS];
    logic [SQ_W-1:0] n_root [0:SQ_STEPS];

    always_comb begin
        logic [SQ_W-1:0] bit_val;
        logic [SQ_W-1:0] trial;
        n_rem[0]  = (SQ_W'(1) << SQ_IN_W) - SQ_W'(i_sq);
        n_root[0] = '0;
        for (int k = 0; k < SQ_STEPS; k++) begin
            bit_val = SQ_W'(1) << (SQ_IN_W - 2 * k);
            trial   = r_root[k] + bit_val;
            if (r_rem[k] >= trial) begin
                n_rem[k+1]  = r_rem[k] - trial;
                n_root[k+1] = (r_root[k] >> 1) + bit_val;
            end else begin
                n_rem[k+1]  = r_rem[k];
                n_root[k+1] = r_root[k] >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= SQ_STEPS; k++) r_v[k] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
            for (int k = 0; k < SQ_STEPS; k++) r_v[k+1] <= r_v[k];
        end
        for (int k = 0; k <= SQ_STEPS; k++) begin
            r_rem[k]  <= n_rem[k];
            r_root[k] <= n_root[k];
        end
    end

    assign o_valid = r_v[SQ_STEPS];
    assign o_root  = r_root[SQ_STEPS][SQ_ROOT_W-1:0];

endmodule

/* rtl/core/qte_cordic.sv */
// Pipelined vectoring CORDIC that forms atan2(y, x) at 65536 per radian.
`timescale 1ns / 1ps

module qte_cordic
    import qte_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  logic signed [CRD_W-1:0] i_y,
    input  logic signed [CRD_W-1:0] i_x,
    output logic                    o_valid,
    output logic signed [ANG_W-1:0] o_angle
);

    logic                    r_v    [0:CORDIC_STAGES];
    logic                    r_zero [0:CORDIC_STAGES];
    logic signed [CRD_W-1:0] r_x    [0:CORDIC_STAGES];
    logic signed [CRD_W-1:0] r_y    [0:CORDIC_STAGES];
    logic signed [ANG_W-1:0] r_z    [0:CORDIC_STAGES];
    logic signed [CRD_W-1:0] n_x    [0:CORDIC_STAGES];
    logic signed [CRD_W-1:0] n_y    [0:CORDIC_STAGES];
    logic signed [ANG_W-1:0] n_z    [0:CORDIC_STAGES];

    always_comb begin
        if (i_x < 0) begin
            n_x[0] = -i_x;
            n_y[0] = -i_y;
            n_z[0] = (i_y >= 0) ? ANG_PI : -ANG_PI;
        end else begin
            n_x[0] = i_x;
            n_y[0] = i_y;
            n_z[0] = '0;
        end
        for (int k = 0; k < CORDIC_STAGES; k++) begin
            if (r_y[k] > 0) begin
                n_x[k+1] = r_x[k] + (r_y[k] >>> k);
                n_y[k+1] = r_y[k] - (r_x[k] >>> k);
                n_z[k+1] = r_z[k] + atan_entry(k);
            end else begin
                n_x[k+1] = r_x[k] - (r_y[k] >>> k);
                n_y[k+1] = r_y[k] + (r_x[k] >>> k);
                n_z[k+1] = r_z[k] - atan_entry(k);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= CORDIC_STAGES; k++) r_v[k] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
            for (int k = 0; k < CORDIC_STAGES; k++) r_v[k+1] <= r_v[k];
        end
        r_zero[0] <= (i_x == 0) && (i_y == 0);
        for (int k = 0; k < CORDIC_STAGES; k++) r_zero[k+1] <= r_zero[k];
        for (int k = 0; k <= CORDIC_STAGES; k++) begin
            r_x[k] <= n_x[k];
            r_y[k] <= n_y[k];
            r_z[k] <= n_z[k];
        end
    end

    assign o_valid = r_v[CORDIC_STAGES];
    assign o_angle = r_zero[CORDIC_STAGES] ? '0 : r_z[CORDIC_STAGES];

endmodule

/* rtl/core/quaternion_to_euler_angles.sv */
// Top level: quaternion to roll, pitch and yaw pipeline with its convention register.
//
// Channel  Direction  Handshake                   Payload
// command  in         start, busy                 i_quat_w, i_quat_x, i_quat_y, i_quat_z
// result   out        o_done (one-cycle strobe)   o_roll_angle, o_pitch_angle, o_yaw_angle,
//                                                 o_pitch_clamped
// config   in/out     psel, penable, pwrite       paddr, pwdata, prdata, pready
//
// One transaction is taken every cycle; busy stays low.
// The result strobes once its transaction has passed the 29-step square root
// and the 16-stage CORDIC that follows it.
// Reset clears the valid bits and sets the convention to standard.
// The receiver cannot stall, so the pipeline never holds.
`timescale 1ns / 1ps

module quaternion_to_euler_angles
    import qte_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] i_quat_w,
    input  logic signed [15:0] i_quat_x,
    input  logic signed [15:0] i_quat_y,
    input  logic signed [15:0] i_quat_z,
    output logic               o_done,
    output logic signed [16:0] o_roll_angle,
    output logic signed [14:0] o_pitch_angle,
    output logic signed [16:0] o_yaw_angle,
    output logic               o_pitch_clamped,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic               paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int   RND_W    = 22;
    localparam logic REG_CONV = 1'b0;

    function automatic logic signed [RND_W-1:0] sat(
        input logic signed [RND_W-1:0] v,
        input logic signed [RND_W-1:0] lo,
        input logic signed [RND_W-1:0] hi
    );
        logic signed [RND_W-1:0] res;
        if (v < lo) begin
            res = lo;
        end else if (v > hi) begin
            res = hi;
        end else begin
            res = v;
        end
        return res;
    endfunction

    logic [1:0] r_mode;

    assign pready = 1'b1;
    assign busy   = 1'b0;
    assign prdata = (paddr == REG_CONV) ? {30'd0, r_mode} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= CONV_STANDARD;
        end else if (psel && penable && pwrite && pready && (paddr == REG_CONV)) begin
            r_mode <= pwdata[1:0];
        end
    end

    logic               r_v1;
    logic signed [15:0] r_w, r_x, r_y, r_z;

    logic                     r_v2;
    logic signed [PROD_W-1:0] r_wx, r_yz, r_xx, r_yy, r_wy, r_zx, r_wz, r_xy, r_zz;

    logic                    r_v3;
    logic signed [SUM_W-1:0] r_sinr, r_cosr, r_sinp, r_siny, r_cosy;
    logic                    r_clamp3;
    logic signed [SUM_W-1:0] n_sinr, n_cosr, n_sinp, n_siny, n_cosy;

    logic                     r_v4;
    logic [SQ_IN_W-1:0]       r_s2;
    t_side                    r_side4;
    logic signed [SINP_W-1:0] w_sinp29;
    logic signed [57:0]       n_s2;

    always_comb begin
        n_sinr = (SUM_W'(r_wx) + SUM_W'(r_yz)) <<< 1;
        n_cosr = ONE_Q28 - ((SUM_W'(r_xx) + SUM_W'(r_yy)) <<< 1);
        n_sinp = (SUM_W'(r_wy) - SUM_W'(r_zx)) <<< 1;
        n_siny = (SUM_W'(r_wz) + SUM_W'(r_xy)) <<< 1;
        n_cosy = ONE_Q28 - ((SUM_W'(r_yy) + SUM_W'(r_zz)) <<< 1);
    end

    assign w_sinp29 = r_sinp[SINP_W-1:0];
    assign n_s2     = w_sinp29 * w_sinp29;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= start && !busy;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
        r_w <= i_quat_w;
        r_x <= i_quat_x;
        r_y <= i_quat_y;
        r_z <= i_quat_z;

        r_wx <= r_w * r_x;
        r_yz <= r_y * r_z;
        r_xx <= r_x * r_x;
        r_yy <= r_y * r_y;
        r_wy <= r_w * r_y;
        r_zx <= r_z * r_x;
        r_wz <= r_w * r_z;
        r_xy <= r_x * r_y;
        r_zz <= r_z * r_z;

        r_sinr   <= n_sinr;
        r_cosr   <= n_cosr;
        r_sinp   <= n_sinp;
        r_siny   <= n_siny;
        r_cosy   <= n_cosy;
        r_clamp3 <= (n_sinp >= ONE_Q28) || (n_sinp <= -ONE_Q28);

        r_s2             <= n_s2[SQ_IN_W-1:0];
        r_side4.sinr     <= r_sinr;
        r_side4.cosr     <= r_cosr;
        r_side4.siny     <= r_siny;
        r_side4.cosy     <= r_cosy;
        r_side4.sinp     <= w_sinp29;
        r_side4.clamped  <= r_clamp3;
        r_side4.positive <= r_sinp > 0;
    end

    logic                 w_sq_valid;
    logic [SQ_ROOT_W-1:0] w_root;
    t_side                r_side_d [0:SQ_LAT-1];
    t_side                w_side;

    qte_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v4),
        .i_sq    (r_s2),
        .o_valid (w_sq_valid),
        .o_root  (w_root)
    );

    always_ff @(posedge i_clk) begin
        r_side_d[0] <= r_side4;
        for (int k = 1; k < SQ_LAT; k++) r_side_d[k] <= r_side_d[k-1];
    end

    assign w_side = r_side_d[SQ_LAT-1];

    logic                    w_vr, w_vy, w_vp;
    logic signed [ANG_W-1:0] w_ar, w_ay, w_ap;
    logic signed [CRD_W-1:0] w_root_x;
    t_pflag                  r_flag_d [0:CRD_LAT-1];
    t_pflag                  w_flag;

    assign w_root_x = {{(CRD_W-SQ_ROOT_W){1'b0}}, w_root};

    qte_cordic u_cordic_roll (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_sq_valid),
        .i_y     (CRD_W'(w_side.sinr)),
        .i_x     (CRD_W'(w_side.cosr)),
        .o_valid (w_vr),
        .o_angle (w_ar)
    );

    qte_cordic u_cordic_yaw (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_sq_valid),
        .i_y     (CRD_W'(w_side.siny)),
        .i_x     (CRD_W'(w_side.cosy)),
        .o_valid (w_vy),
        .o_angle (w_ay)
    );

    qte_cordic u_cordic_pitch (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_sq_valid),
        .i_y     (CRD_W'(w_side.sinp)),
        .i_x     (w_root_x),
        .o_valid (w_vp),
        .o_angle (w_ap)
    );

    always_ff @(posedge i_clk) begin
        r_flag_d[0] <= '{clamped: w_side.clamped, positive: w_side.positive};
        for (int k = 1; k < CRD_LAT; k++) r_flag_d[k] <= r_flag_d[k-1];
    end

    assign w_flag = r_flag_d[CRD_LAT-1];

    logic                    r_va;
    logic signed [RND_W-1:0] r_roll_std, r_roll_neg, r_yaw_std, r_pitch_rnd;
    t_pflag                  r_flag_a;
    logic signed [RND_W-1:0] n_ar, n_ay, n_ap, n_neg;

    always_comb begin
        n_ar  = RND_W'(w_ar);
        n_ay  = RND_W'(w_ay);
        n_ap  = RND_W'(w_ap);
        n_neg = -n_ar - RND_W'(ANG_PI);
    end

    logic                    r_done;
    logic signed [RND_W-1:0] n_roll, n_yaw, n_pitch, n_std_roll, n_std_yaw, n_neg_sat;

    always_comb begin
        n_std_roll = sat(r_roll_std, RND_W'(-OUT_PI), RND_W'(OUT_PI));
        n_std_yaw  = sat(r_yaw_std, RND_W'(-OUT_PI), RND_W'(OUT_PI));
        n_neg_sat  = sat(r_roll_neg, RND_W'(-2 * OUT_PI), RND_W'(OUT_PI));
        case (r_mode)
            CONV_GIMBAL: begin
                n_roll = n_neg_sat;
                n_yaw  = n_std_yaw;
            end
            CONV_TARGET: begin
                n_roll = n_std_yaw;
                n_yaw  = n_neg_sat;
            end
            default: begin
                n_roll = n_std_roll;
                n_yaw  = n_std_yaw;
            end
        endcase
        if (r_flag_a.clamped) begin
            n_pitch = r_flag_a.positive ? RND_W'(OUT_HALF_PI) : RND_W'(-OUT_HALF_PI);
        end else begin
            n_pitch = sat(r_pitch_rnd, RND_W'(-OUT_HALF_PI), RND_W'(OUT_HALF_PI));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_va   <= w_vr && w_vy && w_vp;
            r_done <= r_va;
        end
        r_roll_std  <= (n_ar + RND_W'(4)) >>> 3;
        r_roll_neg  <= (n_neg + RND_W'(4)) >>> 3;
        r_yaw_std   <= (n_ay + RND_W'(4)) >>> 3;
        r_pitch_rnd <= (n_ap + RND_W'(4)) >>> 3;
        r_flag_a    <= w_flag;

        o_roll_angle    <= n_roll[16:0];
        o_yaw_angle     <= n_yaw[16:0];
        o_pitch_angle   <= n_pitch[14:0];
        o_pitch_clamped <= r_flag_a.clamped;
    end

    assign o_done = r_done;

endmodule
